// ===== rtl/rpmd_pkg.sv =====
// ----------------------------------------------------------------------------
// rpmd_pkg
// Shared types, register map and reset values for the RC pulse motor drive.
// ----------------------------------------------------------------------------
`default_nettype none

package rpmd_pkg;

	localparam int unsigned SAMPLES_PER_LEVEL_DEF = 8;
	localparam int unsigned DUTY_BITS_DEF         = 10;

	localparam int unsigned TIMER_W  = 16;
	localparam int unsigned SAMPLE_W = 10;
	localparam int unsigned LEVEL_W  = 13;
	localparam int unsigned SUM_W    = 14;
	localparam int unsigned DB_W     = 10;

	localparam int unsigned APB_AW = 5;
	localparam int unsigned APB_DW = 32;

	localparam int unsigned IN_TDATA_W  = 32;
	localparam int unsigned OUT_TDATA_W = 8;

	localparam logic [DB_W-1:0]    DEADBAND_RST        = 10'd80;
	localparam logic [TIMER_W-1:0] CENTER_WIDTH_RST    = 16'd1500;
	localparam logic [TIMER_W-1:0] WIDTH_MIN_RST       = 16'd800;
	localparam logic [TIMER_W-1:0] WIDTH_MAX_RST       = 16'd2200;
	localparam logic [LEVEL_W-1:0] LEVEL_CRITICAL_RST  = 13'd6305;
	localparam logic [LEVEL_W-1:0] LEVEL_OK_RST        = 13'd7261;
	localparam logic [LEVEL_W-1:0] LEVEL_CHARGED_RST   = 13'd7643;
	localparam logic [TIMER_W-1:0] SAMPLE_INTERVAL_RST = 16'd50000;

	typedef enum logic [2:0] {
		REG_DEADBAND,
		REG_CENTER_WIDTH,
		REG_WIDTH_MIN,
		REG_WIDTH_MAX,
		REG_LEVEL_CRITICAL,
		REG_LEVEL_OK,
		REG_LEVEL_CHARGED,
		REG_SAMPLE_INTERVAL
	} rpmd_reg_t;

	typedef enum logic [1:0] {
		PH_WAIT,
		PH_SAMPLE,
		PH_CLASSIFY,
		PH_SPARE
	} rpmd_phase_t;

	typedef enum logic [1:0] {
		LVL_CRITICAL,
		LVL_LOW,
		LVL_OK,
		LVL_CHARGED
	} rpmd_level_t;

	typedef struct packed {
		logic [DB_W-1:0]    deadband;
		logic [TIMER_W-1:0] center_width;
		logic [TIMER_W-1:0] width_min;
		logic [TIMER_W-1:0] width_max;
		logic [LEVEL_W-1:0] level_critical;
		logic [LEVEL_W-1:0] level_ok;
		logic [LEVEL_W-1:0] level_charged;
		logic [TIMER_W-1:0] sample_interval;
	} rpmd_cfg_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] adc_sample;
		logic                adc_busy;
		logic                rc_level;
		logic [TIMER_W-1:0]  timer_now;
	} rpmd_item_t;

	typedef struct packed {
		rpmd_level_t battery_level;
		logic        adc_start;
		logic        red_on;
		logic        green_lit;
		logic        motor_in2;
		logic        motor_in1;
	} rpmd_result_t;

endpackage

`default_nettype wire

// ===== rtl/rc_pulse_motor_drive_battery_cutoff.sv =====
// ----------------------------------------------------------------------------
// rc_pulse_motor_drive_battery_cutoff
// RC pulse to PWM motor drive with battery level monitor and cutoff.
//
//   Port group  Dir  Width  Contents
//   s_axis      in   32     one timer tick request
//   m_axis      out  8      one drive/indicator result per tick
//   apb         in   5/32   configuration registers at 4*index
//
// One request per clock while the output is not stalled. After accept the result
// passes the input register, then the result register after the per-tick logic.
// Reset is asynchronous; no warm-up is needed after release.
// An output stall holds the result register; the input register then holds too,
// and once it holds a request s_axis_tready drops until the result is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module rc_pulse_motor_drive_battery_cutoff
	import rpmd_pkg::*;
#(
	parameter int unsigned SAMPLES_PER_LEVEL = SAMPLES_PER_LEVEL_DEF,
	parameter int unsigned DUTY_BITS         = DUTY_BITS_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   s_axis_tvalid,
	output logic                        s_axis_tready,
	// timer_now[15:0], rc_level[16], adc_busy[17], adc_sample[27:18], zero pad
	input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
	output logic                        m_axis_tvalid,
	input  wire logic                   m_axis_tready,
	// motor_in1[0], motor_in2[1], green_lit[2], red_on[3], adc_start[4],
	// battery_level[6:5], zero pad
	output logic [OUT_TDATA_W-1:0]      m_axis_tdata,
	input  wire logic                   psel,
	input  wire logic                   penable,
	input  wire logic                   pwrite,
	input  wire logic [APB_AW-1:0]      paddr,
	input  wire logic [APB_DW-1:0]      pwdata,
	output logic      [APB_DW-1:0]      prdata,
	output logic                        pready
);

	rpmd_cfg_t    cfg;
	rpmd_item_t   item_s1;
	logic         valid_s1;
	rpmd_result_t result;
	rpmd_result_t result_s2;
	logic         valid_s2;
	logic         advance;

	rpmd_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign advance       = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			item_s1 <= rpmd_item_t'(s_axis_tdata[$bits(rpmd_item_t)-1:0]);
		end
	end

	rpmd_core #(
		.SAMPLES_PER_LEVEL (SAMPLES_PER_LEVEL),
		.DUTY_BITS         (DUTY_BITS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (advance),
		.cfg    (cfg),
		.item   (item_s1),
		.result (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (m_axis_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= result;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = OUT_TDATA_W'(result_s2);

	a_ready_only_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> (valid_s1 && valid_s2 && !m_axis_tready))
		else $error("input refused without an output stall");

	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !m_axis_tready) |=> valid_s2)
		else $error("pending result lost");

	a_advance_fills: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> valid_s2)
		else $error("advanced request produced no result");

endmodule

`default_nettype wire

// ===== rtl/rpmd_regs.sv =====
// ----------------------------------------------------------------------------
// rpmd_regs
// APB configuration registers: thresholds, pulse limits and sample interval.
// ----------------------------------------------------------------------------
`default_nettype none

module rpmd_regs
	import rpmd_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [APB_AW-1:0] paddr,
	input  wire logic [APB_DW-1:0] pwdata,
	output logic      [APB_DW-1:0] prdata,
	output logic                   pready,
	output rpmd_cfg_t              cfg
);

	rpmd_cfg_t cfg_q;
	rpmd_reg_t idx;
	logic      wr_en;

	assign pready = 1'b1;
	assign idx    = rpmd_reg_t'(paddr[APB_AW-1:2]);
	assign wr_en  = psel && penable && pwrite && pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.deadband        <= DEADBAND_RST;
			cfg_q.center_width    <= CENTER_WIDTH_RST;
			cfg_q.width_min       <= WIDTH_MIN_RST;
			cfg_q.width_max       <= WIDTH_MAX_RST;
			cfg_q.level_critical  <= LEVEL_CRITICAL_RST;
			cfg_q.level_ok        <= LEVEL_OK_RST;
			cfg_q.level_charged   <= LEVEL_CHARGED_RST;
			cfg_q.sample_interval <= SAMPLE_INTERVAL_RST;
		end else if (wr_en) begin
			case (idx)
				REG_DEADBAND:        cfg_q.deadband        <= pwdata[DB_W-1:0];
				REG_CENTER_WIDTH:    cfg_q.center_width    <= pwdata[TIMER_W-1:0];
				REG_WIDTH_MIN:       cfg_q.width_min       <= pwdata[TIMER_W-1:0];
				REG_WIDTH_MAX:       cfg_q.width_max       <= pwdata[TIMER_W-1:0];
				REG_LEVEL_CRITICAL:  cfg_q.level_critical  <= pwdata[LEVEL_W-1:0];
				REG_LEVEL_OK:        cfg_q.level_ok        <= pwdata[LEVEL_W-1:0];
				REG_LEVEL_CHARGED:   cfg_q.level_charged   <= pwdata[LEVEL_W-1:0];
				REG_SAMPLE_INTERVAL: cfg_q.sample_interval <= pwdata[TIMER_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_DEADBAND:        prdata = APB_DW'(cfg_q.deadband);
			REG_CENTER_WIDTH:    prdata = APB_DW'(cfg_q.center_width);
			REG_WIDTH_MIN:       prdata = APB_DW'(cfg_q.width_min);
			REG_WIDTH_MAX:       prdata = APB_DW'(cfg_q.width_max);
			REG_LEVEL_CRITICAL:  prdata = APB_DW'(cfg_q.level_critical);
			REG_LEVEL_OK:        prdata = APB_DW'(cfg_q.level_ok);
			REG_LEVEL_CHARGED:   prdata = APB_DW'(cfg_q.level_charged);
			REG_SAMPLE_INTERVAL: prdata = APB_DW'(cfg_q.sample_interval);
			default:             prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

// ===== rtl/rpmd_core.sv =====
// ----------------------------------------------------------------------------
// rpmd_core
// Per-tick control state: pulse capture, duty and direction, PWM compare,
// battery sampling sequence and indicator states.
// ----------------------------------------------------------------------------
`default_nettype none

module rpmd_core
	import rpmd_pkg::*;
#(
	parameter int unsigned SAMPLES_PER_LEVEL = SAMPLES_PER_LEVEL_DEF,
	parameter int unsigned DUTY_BITS         = DUTY_BITS_DEF
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         en,
	input  wire rpmd_cfg_t    cfg,
	input  wire rpmd_item_t   item,
	output rpmd_result_t      result
);

	localparam int unsigned CNT_W = $clog2(SAMPLES_PER_LEVEL + 1);
	localparam logic [DUTY_BITS-1:0] DUTY_MAX   = '1;
	localparam logic signed [19:0]   DUTY_MAX_S = signed'(20'((1 << DUTY_BITS) - 1));
	localparam logic [CNT_W-1:0]     CNT_LIMIT  = CNT_W'(SAMPLES_PER_LEVEL);

	logic                 rc_prev_q;
	logic [TIMER_W-1:0]   pulse_start_q;
	logic [DUTY_BITS-1:0] duty_q;
	logic                 reverse_q;
	rpmd_phase_t          phase_q;
	logic [SUM_W-1:0]     sum_q;
	logic [CNT_W-1:0]     count_q;
	logic [TIMER_W-1:0]   last_start_q;
	rpmd_level_t          level_q;
	logic                 green_q;
	logic                 red_q;

	logic [TIMER_W-1:0]   pulse_start_d;
	logic [DUTY_BITS-1:0] duty_d;
	logic                 reverse_d;
	rpmd_phase_t          phase_d;
	logic [SUM_W-1:0]     sum_d;
	logic [CNT_W-1:0]     count_d;
	logic [TIMER_W-1:0]   last_start_d;
	rpmd_level_t          level_d;
	logic                 green_d;
	logic                 red_d;
	logic                 start_d;

	logic                 rise;
	logic                 fall;
	logic [TIMER_W-1:0]   width;
	logic                 in_range;
	logic signed [19:0]   w_s, c_s, d_s, p_rev, p_fwd;
	logic [DUTY_BITS-1:0] duty_rev, duty_fwd;
	logic [CNT_W-1:0]     count_inc;
	logic [SUM_W-1:0]     sum_ext;

	assign rise     = item.rc_level && !rc_prev_q;
	assign fall     = !item.rc_level && rc_prev_q && (level_q != LVL_CRITICAL);
	assign width    = item.timer_now - pulse_start_q;
	assign in_range = !(width < cfg.width_min || width > cfg.width_max);

	assign w_s   = signed'(20'(width));
	assign c_s   = signed'(20'(cfg.center_width));
	assign d_s   = signed'(20'(cfg.deadband));
	assign p_rev = (c_s - w_s) <<< 1;
	assign p_fwd = DUTY_MAX_S - ((w_s - c_s) <<< 1);

	assign duty_rev = (p_rev > DUTY_MAX_S) ? DUTY_MAX : p_rev[DUTY_BITS-1:0];
	assign duty_fwd = (p_fwd < 0) ? '0 : p_fwd[DUTY_BITS-1:0];

	// Pulse capture, then battery cutoff.
	always_comb begin
		pulse_start_d = pulse_start_q;
		duty_d        = duty_q;
		reverse_d     = reverse_q;
		if (rise) begin
			pulse_start_d = item.timer_now;
		end else if (fall && in_range) begin
			if (w_s < c_s - d_s) begin
				duty_d    = duty_rev;
				reverse_d = 1'b1;
			end else if (w_s > c_s + d_s) begin
				duty_d    = duty_fwd;
				reverse_d = 1'b0;
			end else begin
				duty_d    = DUTY_MAX;
				reverse_d = 1'b0;
			end
		end
		if (level_q == LVL_CRITICAL) begin
			duty_d    = DUTY_MAX;
			reverse_d = 1'b0;
		end
	end

	assign count_inc = count_q + 1'b1;
	assign sum_ext   = SUM_W'(item.adc_sample);

	// Battery sampling sequence.
	always_comb begin
		phase_d      = phase_q;
		sum_d        = sum_q;
		count_d      = count_q;
		last_start_d = last_start_q;
		level_d      = level_q;
		green_d      = green_q;
		red_d        = red_q;
		start_d      = 1'b0;
		case (phase_q)
			PH_SAMPLE: begin
				if (!item.adc_busy) begin
					sum_d   = sum_q + sum_ext;
					count_d = count_inc;
					phase_d = (count_inc >= CNT_LIMIT) ? PH_CLASSIFY : PH_WAIT;
				end
			end
			PH_CLASSIFY: begin
				if (sum_q < SUM_W'(cfg.level_critical))
					level_d = LVL_CRITICAL;
				else if (sum_q < SUM_W'(cfg.level_ok))
					level_d = LVL_LOW;
				else if (sum_q < SUM_W'(cfg.level_charged))
					level_d = LVL_OK;
				else
					level_d = LVL_CHARGED;
				sum_d   = '0;
				count_d = '0;
				phase_d = PH_WAIT;
				case (level_d)
					LVL_CRITICAL: begin
						green_d = 1'b0;
						red_d   = !red_q;
					end
					LVL_LOW: begin
						green_d = 1'b0;
						red_d   = 1'b1;
					end
					LVL_OK: begin
						green_d = 1'b1;
						red_d   = 1'b0;
					end
					default: begin
						green_d = !green_q;
						red_d   = 1'b0;
					end
				endcase
			end
			default: begin
				if ((item.timer_now - last_start_q) > cfg.sample_interval) begin
					start_d      = 1'b1;
					last_start_d = item.timer_now;
					phase_d      = PH_SAMPLE;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_WAIT;
		end else if (en) begin
			phase_q <= phase_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rc_prev_q     <= 1'b0;
			pulse_start_q <= '0;
			duty_q        <= DUTY_MAX;
			reverse_q     <= 1'b0;
			sum_q         <= '0;
			count_q       <= '0;
			last_start_q  <= '0;
			level_q       <= LVL_LOW;
			green_q       <= 1'b1;
			red_q         <= 1'b1;
		end else if (en) begin
			rc_prev_q     <= item.rc_level;
			pulse_start_q <= pulse_start_d;
			duty_q        <= duty_d;
			reverse_q     <= reverse_d;
			sum_q         <= sum_d;
			count_q       <= count_d;
			last_start_q  <= last_start_d;
			level_q       <= level_d;
			green_q       <= green_d;
			red_q         <= red_d;
		end
	end

	assign result.motor_in1     = duty_d < item.timer_now[DUTY_BITS-1:0];
	assign result.motor_in2     = reverse_d;
	assign result.green_lit     = green_d;
	assign result.red_on        = red_d;
	assign result.adc_start     = start_d;
	assign result.battery_level = level_d;

	a_cutoff: assert property (@(posedge clk) disable iff (!arst_n)
		(en && level_q == LVL_CRITICAL) |=> (duty_q == DUTY_MAX && !reverse_q))
		else $error("motor not forced off at critical battery level");

	a_start_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(en && start_d) |=> (phase_q == PH_SAMPLE))
		else $error("conversion start did not enter sampling");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_LIMIT)
		else $error("sample count beyond samples per level");

	a_classify_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(en && phase_q == PH_CLASSIFY) |=> (sum_q == '0 && count_q == '0))
		else $error("sum not cleared after classification");

endmodule

`default_nettype wire

// ===== sim/rc_pulse_motor_drive_battery_cutoff_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rc_pulse_motor_drive_battery_cutoff_test
// Streams timer ticks carrying RC pulses and converter samples into the drive
// and tracks the drive, the conversion sequence and the indicators tick by
// tick. Each result is checked field by field against the tracked state.
// Runs across default, hand-picked, extreme and random register settings,
// with random gaps on both streams.
// ----------------------------------------------------------------------------

module rc_pulse_motor_drive_battery_cutoff_test;
	import rpmd_pkg::*;

	localparam int DUTY_M = (1 << DUTY_BITS_DEF) - 1;
	localparam int TICKS_PER_RUN = 240;

	class motor_battery_track;
		rpmd_cfg_t          cfg;
		logic               rc_q;
		logic [TIMER_W-1:0] rise_time;
		logic [TIMER_W-1:0] last_conv;
		int                 duty;
		logic               rev;
		rpmd_phase_t        phase;
		logic [SUM_W-1:0]   sum;
		logic [3:0]         cnt;
		rpmd_level_t        lvl;
		logic               green;
		logic               red;
		rpmd_result_t       due[$];
		int                 mismatches;

		function new();
			cfg.deadband = DEADBAND_RST;
			cfg.center_width = CENTER_WIDTH_RST;
			cfg.width_min = WIDTH_MIN_RST;
			cfg.width_max = WIDTH_MAX_RST;
			cfg.level_critical = LEVEL_CRITICAL_RST;
			cfg.level_ok = LEVEL_OK_RST;
			cfg.level_charged = LEVEL_CHARGED_RST;
			cfg.sample_interval = SAMPLE_INTERVAL_RST;
			rc_q = 1'b0;
			rise_time = '0;
			last_conv = '0;
			duty = DUTY_M;
			rev = 1'b0;
			phase = PH_WAIT;
			sum = '0;
			cnt = '0;
			lvl = LVL_LOW;
			green = 1'b1;
			red = 1'b1;
			mismatches = 0;
		endfunction

		function void set_reg(rpmd_reg_t idx, logic [APB_DW-1:0] val);
			case (idx)
			REG_DEADBAND:        cfg.deadband = val[DB_W-1:0];
			REG_CENTER_WIDTH:    cfg.center_width = val[TIMER_W-1:0];
			REG_WIDTH_MIN:       cfg.width_min = val[TIMER_W-1:0];
			REG_WIDTH_MAX:       cfg.width_max = val[TIMER_W-1:0];
			REG_LEVEL_CRITICAL:  cfg.level_critical = val[LEVEL_W-1:0];
			REG_LEVEL_OK:        cfg.level_ok = val[LEVEL_W-1:0];
			REG_LEVEL_CHARGED:   cfg.level_charged = val[LEVEL_W-1:0];
			REG_SAMPLE_INTERVAL: cfg.sample_interval = val[TIMER_W-1:0];
			default: ;
			endcase
		endfunction

		function void apply_width(logic [TIMER_W-1:0] v);
			int w;
			int c;
			int d;
			int p;
			w = v;
			c = cfg.center_width;
			d = cfg.deadband;
			if (v < cfg.width_min || v > cfg.width_max)
				return;
			if (w < c - d) begin
				p = 2 * (c - w);
				duty = (p > DUTY_M) ? DUTY_M : p;
				rev = 1'b1;
			end else if (w > c + d) begin
				p = DUTY_M - 2 * (w - c);
				duty = (p < 0) ? 0 : p;
				rev = 1'b0;
			end else begin
				duty = DUTY_M;
				rev = 1'b0;
			end
		endfunction

		// one accepted request gives exactly one result
		function void take_tick(rpmd_item_t it);
			rpmd_result_t r;
			logic [TIMER_W-1:0] span;
			r = '0;
			span = it.timer_now - rise_time;
			if (it.rc_level && !rc_q)
				rise_time = it.timer_now;
			else if (!it.rc_level && rc_q && lvl != LVL_CRITICAL)
				apply_width(span);
			if (lvl == LVL_CRITICAL) begin
				duty = DUTY_M;
				rev = 1'b0;
			end
			r.motor_in1 = duty < (int'(it.timer_now) & DUTY_M);
			span = it.timer_now - last_conv;
			case (phase)
			PH_SAMPLE: begin
				if (!it.adc_busy) begin
					sum = sum + it.adc_sample;
					cnt = cnt + 1'b1;
					phase = (cnt >= SAMPLES_PER_LEVEL_DEF) ? PH_CLASSIFY : PH_WAIT;
				end
			end
			PH_CLASSIFY: begin
				if (sum < cfg.level_critical)
					lvl = LVL_CRITICAL;
				else if (sum < cfg.level_ok)
					lvl = LVL_LOW;
				else if (sum < cfg.level_charged)
					lvl = LVL_OK;
				else
					lvl = LVL_CHARGED;
				sum = '0;
				cnt = '0;
				phase = PH_WAIT;
				case (lvl)
				LVL_CRITICAL: begin
					green = 1'b0;
					red = ~red;
				end
				LVL_LOW: begin
					green = 1'b0;
					red = 1'b1;
				end
				LVL_OK: begin
					green = 1'b1;
					red = 1'b0;
				end
				default: begin
					green = ~green;
					red = 1'b0;
				end
				endcase
			end
			default: begin
				if (span > cfg.sample_interval) begin
					r.adc_start = 1'b1;
					last_conv = it.timer_now;
					phase = PH_SAMPLE;
				end
			end
			endcase
			rc_q = it.rc_level;
			r.motor_in2 = rev;
			r.green_lit = green;
			r.red_on = red;
			r.battery_level = lvl;
			due.push_back(r);
		endfunction

		function void match_field(string name, logic [1:0] want, logic [1:0] got);
			if (got !== want) begin
				$display("%0t: %s expected %0d got %0d", $time, name, want, got);
				mismatches++;
			end
		endfunction

		function void check_output(logic [OUT_TDATA_W-1:0] data);
			rpmd_result_t got;
			rpmd_result_t want;
			got = rpmd_result_t'(data[$bits(rpmd_result_t)-1:0]);
			if (due.size() == 0) begin
				$display("%0t: result %h expected none", $time, data);
				mismatches++;
				return;
			end
			want = due.pop_front();
			match_field("motor_in1", want.motor_in1, got.motor_in1);
			match_field("motor_in2", want.motor_in2, got.motor_in2);
			match_field("green_lit", want.green_lit, got.green_lit);
			match_field("red_on", want.red_on, got.red_on);
			match_field("adc_start", want.adc_start, got.adc_start);
			match_field("battery_level", want.battery_level, got.battery_level);
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [IN_TDATA_W-1:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [APB_AW-1:0] paddr = '0;
	logic [APB_DW-1:0] pwdata = '0;
	logic [APB_DW-1:0] prdata;
	logic pready;

	motor_battery_track trk;

	logic [TIMER_W-1:0] tmr = '0;
	logic [TIMER_W-1:0] rise_at = '0;
	logic [TIMER_W-1:0] target_w = '0;
	logic rc_now = 1'b0;
	int hold_left = 0;
	int batt = 900;
	logic no_idle = 1'b0;
	int stall_left = 0;

	rc_pulse_motor_drive_battery_cutoff i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (no_idle || roll < 70)
			return 0;
		if (roll < 97)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic logic [TIMER_W-1:0] pick_width();
		logic [TIMER_W-1:0] c;
		logic [TIMER_W-1:0] d;
		c = trk.cfg.center_width;
		d = TIMER_W'(trk.cfg.deadband);
		case ($urandom_range(0, 8))
		0: return trk.cfg.width_min;
		1: return trk.cfg.width_max;
		2: return trk.cfg.width_min - 1'b1;
		3: return trk.cfg.width_max + 1'b1;
		4: return c - d - TIMER_W'($urandom_range(0, 2));
		5: return c + d + TIMER_W'($urandom_range(0, 2));
		6: return TIMER_W'($urandom);
		7: return c + TIMER_W'($urandom_range(0, 1200)) - 16'd600;
		default: return TIMER_W'($urandom_range(trk.cfg.width_min, trk.cfg.width_max));
		endcase
	endfunction

	task automatic send_tick(input rpmd_item_t it);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= IN_TDATA_W'(it);
		do @(posedge clk); while (!s_axis_tready);
		trk.take_tick(it);
		@(negedge clk);
	endtask

	task automatic drive_tick(input logic [TIMER_W-1:0] t, input logic rc, input logic busy,
			input logic [SAMPLE_W-1:0] sample);
		rpmd_item_t it;
		it.timer_now = t;
		it.rc_level = rc;
		it.adc_busy = busy;
		it.adc_sample = sample;
		send_tick(it);
		tmr = t;
		rc_now = rc;
	endtask

	task automatic pulse(input logic [TIMER_W-1:0] rise, input logic [TIMER_W-1:0] width);
		drive_tick(rise, 1'b1, 1'($urandom), SAMPLE_W'($urandom));
		drive_tick(rise + width, 1'b0, 1'($urandom), SAMPLE_W'($urandom));
	endtask

	// mostly whole pulses of chosen width; some timer jumps and stray edges
	task automatic make_tick(output rpmd_item_t it);
		int roll;
		int step;
		int v;
		roll = $urandom_range(0, 99);
		step = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, 12);
		if (roll < 4) begin
			tmr = TIMER_W'($urandom);
		end else if (roll < 7) begin
			rc_now = ~rc_now;
			hold_left = $urandom_range(0, 4);
			tmr = tmr + TIMER_W'(step);
		end else if (hold_left > 0) begin
			hold_left--;
			tmr = tmr + TIMER_W'(step);
		end else if (rc_now) begin
			tmr = rise_at + target_w;
			rc_now = 1'b0;
			hold_left = $urandom_range(0, 8);
		end else begin
			tmr = tmr + TIMER_W'(step);
			rc_now = 1'b1;
			rise_at = tmr;
			target_w = pick_width();
			hold_left = $urandom_range(0, 4);
		end
		// battery voltage drifts between the class boundaries
		if ($urandom_range(0, 149) == 0) begin
			case ($urandom_range(0, 3))
			0: batt = trk.cfg.level_critical / 8;
			1: batt = trk.cfg.level_ok / 8;
			2: batt = trk.cfg.level_charged / 8;
			default: batt = $urandom_range(0, 1023);
			endcase
		end
		v = batt + int'($urandom_range(0, 6)) - 3;
		if (v < 0)
			v = 0;
		if (v > 1023)
			v = 1023;
		if ($urandom_range(0, 19) == 0)
			v = $urandom_range(0, 1023);
		it.timer_now = tmr;
		it.rc_level = rc_now;
		it.adc_busy = ($urandom_range(0, 2) == 0);
		it.adc_sample = SAMPLE_W'(v);
	endtask

	task automatic run_ticks(input int n);
		rpmd_item_t it;
		for (int k = 0; k < n; k++) begin
			if (k % 60 == 0)
				no_idle <= ($urandom_range(0, 3) == 0);
			make_tick(it);
			send_tick(it);
		end
		s_axis_tvalid <= 1'b0;
	endtask

	task automatic settle();
		while (trk.due.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input rpmd_reg_t idx, input logic [APB_DW-1:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		trk.set_reg(idx, val);
		@(negedge clk);
	endtask

	task automatic configure(input int db, input int cw, input int wmin, input int wmax,
			input int lc, input int lo, input int lh, input int iv);
		settle();
		write_reg(REG_DEADBAND, db);
		write_reg(REG_CENTER_WIDTH, cw);
		write_reg(REG_WIDTH_MIN, wmin);
		write_reg(REG_WIDTH_MAX, wmax);
		write_reg(REG_LEVEL_CRITICAL, lc);
		write_reg(REG_LEVEL_OK, lo);
		write_reg(REG_LEVEL_CHARGED, lh);
		write_reg(REG_SAMPLE_INTERVAL, iv);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			m_axis_tready <= 1'b0;
		end else if (!no_idle && $urandom_range(0, 99) < 15) begin
			stall_left = ($urandom_range(0, 24) == 0) ? $urandom_range(10, 50) :
				$urandom_range(0, 2);
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	always @(posedge clk)
		if (arst_n && m_axis_tvalid && m_axis_tready)
			trk.check_output(m_axis_tdata);

	initial begin
		#5_000_000;
		$display("rc_pulse_motor_drive_battery_cutoff regression: fail");
		$finish;
	end

	initial begin
		int cw;
		int lc;
		int lo;
		int lh;
		trk = new();
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset settings: centre, both limits, just outside, deadband edges, wrap
		drive_tick(16'd0, 1'b0, 1'b1, 10'd0);
		pulse(16'd100, 16'd1500);
		pulse(16'd2000, 16'd800);
		pulse(16'd3000, 16'd2200);
		pulse(16'd6000, 16'd799);
		pulse(16'd7000, 16'd2201);
		pulse(16'd10000, 16'd1419);
		pulse(16'd12000, 16'd1581);
		pulse(16'd14000, 16'd1420);
		pulse(16'd14500, 16'd1580);
		pulse(16'd65000, 16'd1600);
		drive_tick(16'hFFFF, 1'b0, 1'b0, 10'h3FF);
		drive_tick(16'h03FF, 1'b0, 1'b1, 10'h3FF);
		drive_tick(16'h0000, 1'b0, 1'b0, 10'h3FF);
		run_ticks(TICKS_PER_RUN);

		configure(40, 1000, 500, 1500, 3000, 5000, 7000, 30);
		run_ticks(TICKS_PER_RUN);
		configure(0, 0, 0, 65535, 0, 0, 0, 0);
		run_ticks(TICKS_PER_RUN);
		configure(1023, 65535, 0, 65535, 8184, 8184, 8184, 65535);
		run_ticks(TICKS_PER_RUN);
		// minimum above maximum: every width refused, battery forced critical
		configure(200, 1500, 3000, 1000, 8184, 8184, 8184, 3);
		run_ticks(150);
		repeat (2) begin
			lc = $urandom_range(0, 8184);
			lo = $urandom_range(lc, 8184);
			lh = $urandom_range(lo, 8184);
			cw = $urandom_range(600, 3000);
			configure($urandom_range(0, 300), cw, cw - int'($urandom_range(0, 900)),
				cw + int'($urandom_range(0, 900)), lc, lo, lh, $urandom_range(0, 400));
			run_ticks(200);
		end

		settle();
		repeat (10) @(negedge clk);
		if (trk.mismatches == 0 && trk.due.size() == 0)
			$display("rc_pulse_motor_drive_battery_cutoff regression: pass");
		else
			$display("rc_pulse_motor_drive_battery_cutoff regression: fail");
		$finish;
	end

endmodule
